// ===== hdl/ebrm_pkg.sv =====
// Shared constants and types for the ECG beat rate meter.
// Used by ecg_beat_rate_meter; depends on nothing else.
package ebrm_pkg;

  // Beats in one measured set.
  localparam int unsigned Beats = 10;

  // Field and register widths.
  localparam int unsigned SampleW  = 12;
  localparam int unsigned ThreshW  = 12;
  localparam int unsigned RefracW  = 16;
  localparam int unsigned TimeW    = 32;
  localparam int unsigned BpmW     = 16;
  localparam int unsigned CfgDataW = 16;
  localparam int unsigned CfgIdxW  = 1;

  // Reset values of the configuration registers.
  localparam logic [ThreshW-1:0] ThreshReset = ThreshW'(2350);
  localparam logic [RefracW-1:0] RefracReset = RefracW'(600);

  // Dividend of the rate division: milliseconds per minute times intervals.
  localparam int unsigned MsPerMinute = 60000;
  localparam int unsigned RateNum     = MsPerMinute * (Beats - 1);
  localparam int unsigned NumW        = $clog2(RateNum + 1);
  localparam int unsigned CntW        = $clog2(NumW);
  localparam int unsigned BeatCntW    = $clog2(Beats + 1);

  localparam logic [BpmW-1:0] BpmMax = {BpmW{1'b1}};

  // Configuration register indexes.
  typedef enum logic [CfgIdxW-1:0] {
    REG_THRESHOLD  = 1'b0,
    REG_REFRACTORY = 1'b1
  } cfg_reg_e;

  // Sequencer states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_DONE
  } ebrm_state_e;

endpackage

// ===== hdl/ecg_beat_rate_meter.sv =====
// Top level of the ECG beat rate meter: beat detection, set timing and an
// iterative restoring divider for the rate. Depends on ebrm_pkg.
//
// One input beat is one millisecond tick carrying a 12-bit sample and two
// lead-off flags. Ticks are taken while the sequencer is idle; a tick that
// completes a set of Beats counted heart beats starts the restoring divider,
// which resolves the NumW quotient bits (20 for ten beats) one per cycle and
// then hands the rate to the output register once it is free. While the
// divider runs the input is stalled. The result waits in its own output
// register, so the next ticks are taken while it is still stalled; only a new
// finished division waits for that register to empty. Configuration writes
// take effect at the next clock edge and are meant for idle periods only.
module ecg_beat_rate_meter
  import ebrm_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  // Configuration write port
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i,
  // Sample channel
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [SampleW-1:0]  sample_i,
  input  logic                lead_off_neg_i,
  input  logic                lead_off_pos_i,
  // Rate channel
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [BpmW-1:0]     bpm_o
);

  ebrm_state_e          state_q, state_d;
  logic [ThreshW-1:0]   thresh_q;
  logic [RefracW-1:0]   refrac_q;
  logic [TimeW-1:0]     tick_q;
  logic [TimeW-1:0]     first_q, first_d;
  logic [TimeW-1:0]     last_q, last_d;
  logic [BeatCntW-1:0]  beats_q, beats_d;
  logic [TimeW-1:0]     div_q;
  logic [TimeW-1:0]     rem_q;
  logic [NumW-1:0]      quot_q;
  logic [CntW-1:0]      cnt_q;
  logic                 out_valid_q;
  logic [BpmW-1:0]      bpm_q;

  logic                 in_acc;
  logic                 out_acc;
  logic                 is_beat;
  logic [TimeW-1:0]     since_last;
  logic                 refrac_over;
  logic                 set_done;
  logic                 div_start;
  logic                 load_out;
  logic [TimeW:0]       rem_sh;
  logic [TimeW+1:0]     rem_sub;
  logic                 q_bit;
  logic [BpmW-1:0]      bpm_sat;

  assign in_acc  = in_valid_i && !in_stall_o;
  assign out_acc = out_valid_q && !out_stall_i;

  // Beat test and refractory check on the current tick.
  assign is_beat     = !lead_off_neg_i && !lead_off_pos_i && (sample_i > thresh_q);
  assign since_last  = tick_q - last_q;
  assign refrac_over = since_last > TimeW'(refrac_q);

  // Set bookkeeping for an accepted tick.
  always_comb begin
    first_d  = first_q;
    last_d   = last_q;
    beats_d  = beats_q;
    set_done = 1'b0;
    if (in_acc && is_beat) begin
      if (beats_q == '0) begin
        first_d = tick_q;
        last_d  = tick_q;
        beats_d = BeatCntW'(1);
      end else if (refrac_over) begin
        last_d = tick_q;
        if (beats_q == BeatCntW'(Beats - 1)) begin
          beats_d  = '0;
          set_done = 1'b1;
        end else begin
          beats_d = beats_q + BeatCntW'(1);
        end
      end
    end
  end

  // Sequencer: next state and control.
  always_comb begin
    state_d    = state_q;
    in_stall_o = 1'b1;
    div_start  = 1'b0;
    load_out   = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_acc && set_done) begin
          div_start = 1'b1;
          state_d   = ST_DIV;
        end
      end
      ST_DIV: begin
        if (cnt_q == '0) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid_q || out_acc) begin
          load_out = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // One restoring division step: shift in the next dividend bit and subtract.
  assign rem_sh  = {rem_q, quot_q[NumW-1]};
  assign rem_sub = {1'b0, rem_sh} - {2'b00, div_q};
  assign q_bit   = !rem_sub[TimeW+1];

  // A zero span leaves all quotient bits set, which saturates as well.
  assign bpm_sat = ((TimeW+1)'(quot_q) > (TimeW+1)'(BpmMax)) ? BpmMax : BpmW'(quot_q);

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      thresh_q    <= ThreshReset;
      refrac_q    <= RefracReset;
      tick_q      <= '0;
      first_q     <= '0;
      last_q      <= '0;
      beats_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      first_q  <= first_d;
      last_q   <= last_d;
      beats_q  <= beats_d;
      if (in_acc) begin
        tick_q <= tick_q + TimeW'(1);
      end
      if (cfg_we_i) begin
        case (cfg_reg_e'(cfg_idx_i))
          REG_THRESHOLD:  thresh_q <= cfg_wdata_i[ThreshW-1:0];
          REG_REFRACTORY: refrac_q <= cfg_wdata_i[RefracW-1:0];
          default: ;
        endcase
      end
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_acc) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Divider and output payload registers.
  always_ff @(posedge clk_i) begin
    if (div_start) begin
      // The completing beat is the last one, so the span ends at this tick.
      div_q  <= tick_q - first_q;
      rem_q  <= '0;
      quot_q <= NumW'(RateNum);
      cnt_q  <= CntW'(NumW - 1);
    end else if (state_q == ST_DIV) begin
      rem_q  <= q_bit ? rem_sub[TimeW-1:0] : rem_sh[TimeW-1:0];
      quot_q <= {quot_q[NumW-2:0], q_bit};
      cnt_q  <= cnt_q - CntW'(1);
    end
    if (load_out) begin
      bpm_q <= bpm_sat;
    end
  end

  assign out_valid_o = out_valid_q;
  assign bpm_o       = bpm_q;

endmodule

// ===== dv/ecg_beat_rate_meter_tb.sv =====
`timescale 1ns / 100ps
// Testbench for ecg_beat_rate_meter: drives millisecond ticks and register
// writes, predicts every rate beat in a scoreboard class and compares them.
// Depends on ebrm_pkg and ecg_beat_rate_meter.
module ecg_beat_rate_meter_tb;
  import ebrm_pkg::*;

  localparam int unsigned SampleMax   = (1 << SampleW) - 1;
  localparam int unsigned TickTarget  = 1550;
  localparam int unsigned RateTarget  = 40;
  localparam int unsigned DrainCycles = 40;
  localparam int unsigned DrainLimit  = 20000;
  localparam int unsigned HoldCycles  = 400;
  localparam int unsigned RunLimitNs  = 20_000_000;

  // Tracks the heart beat timing of the block and holds the rates still owed.
  class rate_scoreboard;
    logic [ThreshW-1:0] threshold;
    logic [RefracW-1:0] refractory;
    logic [TimeW-1:0]   now_ms;
    logic [TimeW-1:0]   first_ms;
    logic [TimeW-1:0]   last_ms;
    logic [6:0]         heart_beats;
    logic [BpmW-1:0]    expected_bpm[$];
    int unsigned        errors;
    int unsigned        rates_seen;

    function new();
      threshold   = ThreshReset;
      refractory  = RefracReset;
      now_ms      = '0;
      first_ms    = '0;
      last_ms     = '0;
      heart_beats = '0;
      errors      = 0;
      rates_seen  = 0;
    endfunction

    function void write_reg(cfg_reg_e idx, logic [CfgDataW-1:0] data);
      case (idx)
        REG_THRESHOLD:  threshold  = data[ThreshW-1:0];
        REG_REFRACTORY: refractory = data[RefracW-1:0];
        default: ;
      endcase
    endfunction

    // Advances time by one tick and queues a rate when a set completes.
    function void note_tick(logic [SampleW-1:0] sample, logic neg_off, logic pos_off);
      logic [TimeW-1:0] tick_ms;
      logic [TimeW-1:0] span;
      logic [63:0]      quot;
      tick_ms = now_ms;
      now_ms  = now_ms + 1'b1;
      if (neg_off || pos_off || sample <= threshold) return;

      if (heart_beats == '0) begin
        first_ms    = tick_ms;
        last_ms     = tick_ms;
        heart_beats = 7'd1;
      end else if ((tick_ms - last_ms) > {16'd0, refractory}) begin
        last_ms     = tick_ms;
        heart_beats = heart_beats + 7'd1;
      end

      if (heart_beats >= Beats) begin
        span = last_ms - first_ms;
        if (span == '0) begin
          expected_bpm.push_back(BpmMax);
        end else begin
          quot = 64'(RateNum) / 64'(span);
          expected_bpm.push_back((quot > 64'(BpmMax)) ? BpmMax : quot[BpmW-1:0]);
        end
        heart_beats = '0;
      end
    endfunction

    function void check_bpm(logic [BpmW-1:0] bpm);
      logic [BpmW-1:0] want;
      rates_seen++;
      if (expected_bpm.size() == 0) begin
        $error("bpm %0d arrived with no rate expected", bpm);
        errors++;
        return;
      end
      want = expected_bpm.pop_front();
      if (bpm !== want) begin
        $error("bpm expected %0d actual %0d", want, bpm);
        errors++;
      end
    endfunction
  endclass

  logic                clk_i;
  logic                rst_ni;
  logic                cfg_we_i;
  logic [CfgIdxW-1:0]  cfg_idx_i;
  logic [CfgDataW-1:0] cfg_wdata_i;
  logic                in_valid_i;
  logic                in_stall_o;
  logic [SampleW-1:0]  sample_i;
  logic                lead_off_neg_i;
  logic                lead_off_pos_i;
  logic                out_valid_o;
  logic                out_stall_i;
  logic [BpmW-1:0]     bpm_o;

  rate_scoreboard sb;
  bit             tx_gaps  = 1'b1;
  bit             rx_gaps  = 1'b1;
  bit             hold_req = 1'b0;
  int unsigned    ticks_sent = 0;

  ecg_beat_rate_meter dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .sample_i       (sample_i),
    .lead_off_neg_i (lead_off_neg_i),
    .lead_off_pos_i (lead_off_pos_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .bpm_o          (bpm_o)
  );

  // 50 MHz clock.
  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Hard stop in case the block hangs.
  initial begin
    #RunLimitNs;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // Mostly no pause, some short ones and a few long ones.
  function automatic int unsigned pick_pause();
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 65) return 0;
    if (roll < 93) return $urandom_range(3, 1);
    return $urandom_range(40, 8);
  endfunction

  function automatic logic [SampleW-1:0] beat_level(logic [ThreshW-1:0] thr);
    if (thr == '1) return '1;
    return SampleW'($urandom_range(SampleMax, int'(thr) + 1));
  endfunction

  function automatic logic [SampleW-1:0] rest_level(logic [ThreshW-1:0] thr);
    return SampleW'($urandom_range(int'(thr), 0));
  endfunction

  // Offers one tick after an optional pause and waits until it is taken.
  task automatic send_tick(input logic [SampleW-1:0] sample, input logic neg_off,
                           input logic pos_off);
    int unsigned gap;
    gap = tx_gaps ? pick_pause() : 0;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    sample_i       <= sample;
    lead_off_neg_i <= neg_off;
    lead_off_pos_i <= pos_off;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    sb.note_tick(sample, neg_off, pos_off);
    ticks_sent++;
  endtask

  // Stops offering ticks and lets every owed rate drain out of the block.
  task automatic settle();
    int unsigned waited;
    waited = 0;
    in_valid_i <= 1'b0;
    while (sb.expected_bpm.size() != 0 && waited < DrainLimit) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  // One register write, after which the write enable is driven low again.
  task automatic write_reg(input cfg_reg_e idx, input logic [CfgDataW-1:0] data);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    sb.write_reg(idx, data);
    @(posedge clk_i);
  endtask

  // Trains of heart beats spaced around the refractory time, mixed with noise.
  task automatic random_phase(input int unsigned n_ticks);
    int unsigned        left;
    int unsigned        quiet;
    int unsigned        roll;
    logic               off;
    logic [ThreshW-1:0] thr;
    logic [RefracW-1:0] refr;
    thr  = sb.threshold;
    refr = sb.refractory;
    left = n_ticks;
    while (left > 0) begin
      roll = $urandom_range(99);
      if (roll < 15) begin
        send_tick(SampleW'($urandom), $urandom_range(3) == 0, $urandom_range(3) == 0);
        left--;
      end else begin
        send_tick(beat_level(thr), 1'b0, 1'b0);
        left--;
        // Some next heart beats come early, most just clear the refractory time.
        if (roll < 27) quiet = $urandom_range(int'(refr));
        else quiet = int'(refr) + $urandom_range(2);
        while (quiet > 0 && left > 0) begin
          off = ($urandom_range(9) == 0);
          if (off) send_tick(beat_level(thr), 1'($urandom_range(1)), 1'b1);
          else send_tick(rest_level(thr), 1'b0, 1'b0);
          quiet--;
          left--;
        end
      end
    end
  endtask

  // Receiver: checks each rate beat and picks its own stall pattern.
  initial begin
    int unsigned stall_left;
    stall_left = 0;
    out_stall_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_valid_o && !out_stall_i) sb.check_bpm(bpm_o);
      if (stall_left > 0) begin
        stall_left--;
      end else if (hold_req) begin
        hold_req   = 1'b0;
        stall_left = HoldCycles;
      end else if (rx_gaps) begin
        stall_left = pick_pause();
      end
      out_stall_i <= (stall_left > 0);
    end
  end

  // Sender: directed ticks, then phases of random settings and heart beats.
  initial begin
    int unsigned        phase;
    logic [ThreshW-1:0] thr;
    logic [RefracW-1:0] refr;
    sb = new();
    rst_ni         <= 1'b0;
    cfg_we_i       <= 1'b0;
    cfg_idx_i      <= REG_THRESHOLD;
    cfg_wdata_i    <= '0;
    in_valid_i     <= 1'b0;
    sample_i       <= '0;
    lead_off_neg_i <= 1'b0;
    lead_off_pos_i <= 1'b0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset settings: just above threshold, inside the refractory time, at threshold.
    send_tick(12'd2351, 1'b0, 1'b0);
    send_tick(12'd4095, 1'b0, 1'b0);
    send_tick(12'd2350, 1'b0, 1'b0);
    settle();

    // Threshold 2000 written with junk in the upper data bits, no refractory time.
    write_reg(REG_THRESHOLD, 16'hF7D0);
    write_reg(REG_REFRACTORY, 16'd0);
    send_tick(12'd4095, 1'b1, 1'b0);
    send_tick(12'd4095, 1'b0, 1'b1);
    send_tick(12'd2000, 1'b0, 1'b0);
    send_tick(12'd2001, 1'b0, 1'b0);
    repeat (8) send_tick(12'd4095, 1'b0, 1'b0);
    // Ten heart beats on back-to-back ticks give the shortest possible span.
    repeat (10) send_tick(12'd4095, 1'b0, 1'b0);

    phase = 0;
    while (ticks_sent < TickTarget || sb.rates_seen < RateTarget) begin
      settle();
      case (phase)
        0: begin
          thr  = ThreshW'($urandom_range(3000));
          refr = '1;
        end
        1: begin
          thr  = '1;
          refr = '0;
        end
        2: begin
          thr  = '0;
          refr = '0;
        end
        default: begin
          case ($urandom_range(9))
            0:       thr = '0;
            1:       thr = '1;
            default: thr = ThreshW'($urandom_range(SampleMax));
          endcase
          case ($urandom_range(19))
            0:             refr = '1;
            1, 2, 3, 4:    refr = RefracW'($urandom_range(30, 5));
            default:       refr = RefracW'($urandom_range(4));
          endcase
        end
      endcase
      write_reg(REG_THRESHOLD, {4'($urandom), thr});
      write_reg(REG_REFRACTORY, refr);
      tx_gaps = ($urandom_range(4) != 0);
      rx_gaps = ($urandom_range(4) != 0);

      if (phase == 5) begin
        // Receiver holds off while full-rate heart beats keep completing sets.
        write_reg(REG_THRESHOLD, 16'd100);
        write_reg(REG_REFRACTORY, 16'd0);
        tx_gaps  = 1'b0;
        hold_req = 1'b1;
        repeat (80) send_tick(beat_level(12'd100), 1'b0, 1'b0);
      end else begin
        random_phase($urandom_range(120, 40));
      end
      phase++;
    end

    settle();
    if (sb.expected_bpm.size() != 0) begin
      $error("%0d bpm results never arrived", sb.expected_bpm.size());
      sb.errors++;
    end
    if (sb.errors == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

// ===== ecg_beat_rate_meter.f =====
hdl/ebrm_pkg.sv
hdl/ecg_beat_rate_meter.sv
dv/ecg_beat_rate_meter_tb.sv
